FILE: rtl/grid_cell_count_sizer_unit_defines.svh
// Assertion macros for the grid cell count sizer.
`ifndef GRID_CELL_COUNT_SIZER_UNIT_DEFINES_SVH
`define GRID_CELL_COUNT_SIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GCCS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("gccs assertion failed");
// next-cycle implication
`define GCCS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("gccs assertion failed");
`else
`define GCCS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define GCCS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

FILE: rtl/gccs_pkg.sv
// Shared types and constants of the grid cell count sizer.
package gccs_pkg;

    localparam int LENGTH_WIDTH = 32;
    localparam int MAG_WIDTH    = LENGTH_WIDTH - 1;
    localparam int COUNT_WIDTH  = 24;
    localparam int CELL_WIDTH   = 16;
    localparam int MAX_DIM      = 3;
    localparam int GW           = 2;
    localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH    = SQ_WIDTH + 2;
    localparam int CL_WIDTH     = COUNT_WIDTH + MAG_WIDTH;
    localparam int RHS_WIDTH    = CL_WIDTH + MAG_WIDTH;
    localparam int EPS_ROOT     = 10000;
    localparam int SQK_WIDTH    = SQ_WIDTH + 14;
    localparam int SQE_WIDTH    = SQK_WIDTH + 14;
    localparam int POW_WIDTH    = 3 * CELL_WIDTH;
    localparam int PROD_WIDTH   = SQ_WIDTH + POW_WIDTH;
    localparam int FRAC_ONE     = 65536;
    localparam int PREP_STAGES  = 4;

    // root degree codes
    localparam logic [GW-1:0] G_ONE   = 2'd1;
    localparam logic [GW-1:0] G_TWO   = 2'd2;
    localparam logic [GW-1:0] G_THREE = 2'd3;

    typedef logic [MAG_WIDTH-1:0]   mag_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CELL_WIDTH-1:0]  cell_t;
    typedef logic [SQ_WIDTH-1:0]    base_t;
    typedef logic [RHS_WIDTH-1:0]   rhs_t;
    typedef logic [CL_WIDTH-1:0]    cl_t;

    typedef struct packed {
        logic ok;
        logic deg;
    } lane_tag_t;

    typedef struct packed {
        lane_tag_t     tag;
        logic [GW-1:0] g;
        base_t         base;
        rhs_t          rhs;
    } lane_in_t;

    typedef struct packed {
        logic signed [LENGTH_WIDTH-1:0] length_x;
        logic signed [LENGTH_WIDTH-1:0] length_y;
        logic signed [LENGTH_WIDTH-1:0] length_z;
        count_t                         element_count;
    } box_t;

    typedef struct packed {
        cell_t cells_x;
        cell_t cells_y;
        cell_t cells_z;
        logic  sizes_valid;
    } cells_t;

endpackage

FILE: rtl/grid_cell_count_sizer_unit.sv
// Top level of the grid cell count sizer: front end, root lanes, merge and output register.
//
//  channel | dir | handshake                   | word
//  box     | in  | box_valid / box_ready       | gccs_pkg::box_t   (three sides, count)
//  cells   | out | cells_valid / cells_ready   | gccs_pkg::cells_t (three counts, valid)
//
// One word per cycle sustained while results are drained; a word passes through
// 4 front-end stages, 16 search stages (one bit per stage), then the output register.
// The whole pipeline advances together; a stalled result word holds every stage
// and drops box_ready, so no word is lost or repeated.
// rst_n is asynchronous and clears only the valid bits; data registers are not reset.
`include "grid_cell_count_sizer_unit_defines.svh"

module grid_cell_count_sizer_unit #(
    parameter int DIMENSIONS = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    output logic             box_ready,
    input  gccs_pkg::box_t   box,
    output logic             cells_valid,
    input  logic             cells_ready,
    output gccs_pkg::cells_t cells
);
    import gccs_pkg::*;

    localparam int PIPE_DEPTH = PREP_STAGES + CELL_WIDTH;

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  cells_valid_reg;
    cells_t                cells_reg;
    cells_t                cells_next;

    lane_in_t  lane_in  [DIMENSIONS];
    cell_t     lane_n   [DIMENSIONS];
    lane_tag_t lane_tag [DIMENSIONS];
    cell_t     merged   [MAX_DIM];

    // the whole pipe moves when the output register is empty or being drained
    assign adv       = !cells_valid_reg || cells_ready;
    assign box_ready = adv;

    gccs_prep #(
        .DIMENSIONS(DIMENSIONS)
    ) u_prep (
        .clk    (clk),
        .adv    (adv),
        .box    (box),
        .lane_in(lane_in)
    );

    // one search lane per axis
    for (genvar d = 0; d < DIMENSIONS; d++)
    begin : g_lane
        gccs_root_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .lane_in(lane_in[d]),
            .n      (lane_n[d]),
            .tag    (lane_tag[d])
        );
    end

    // merge: degenerate axes get 1, others at least 1, invalid boxes all zero
    for (genvar d = 0; d < MAX_DIM; d++)
    begin : g_merge
        if (d < DIMENSIONS)
        begin : g_used
            always_comb
            begin
                if (!lane_tag[d].ok)
                begin
                    merged[d] = '0;
                end
                else if (lane_tag[d].deg || lane_n[d] == '0)
                begin
                    merged[d] = CELL_WIDTH'(1);
                end
                else
                begin
                    merged[d] = lane_n[d];
                end
            end
        end
        else
        begin : g_unused
            assign merged[d] = '0;
        end
    end

    always_comb
    begin
        cells_next.cells_x     = merged[0];
        cells_next.cells_y     = merged[1];
        cells_next.cells_z     = merged[2];
        cells_next.sizes_valid = lane_tag[0].ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            cells_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg         <= {vld_reg[PIPE_DEPTH-2:0], box_valid};
            cells_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cells_reg <= cells_next;
        end
    end

    assign cells_valid = cells_valid_reg;
    assign cells       = cells_reg;

    // an accepted box enters the first valid stage
    `GCCS_ASSERT_NEXT(a_accept_enters, clk, rst_n, box_valid && box_ready, vld_reg[0])
    // a valid result never carries a zero count on the x or y axis
    `GCCS_ASSERT_IMPLY(a_valid_nonzero, clk, rst_n, cells_valid && cells.sizes_valid, cells.cells_x != '0 && cells.cells_y != '0)
    // an invalid box yields all-zero counts
    `GCCS_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, cells_valid && !cells.sizes_valid, cells.cells_x == '0 && cells.cells_y == '0 && cells.cells_z == '0)

endmodule

FILE: rtl/gccs_prep.sv
// Front end: squares, degenerate test, and per-lane search bounds.
module gccs_prep #(
    parameter int DIMENSIONS = 3
) (
    input  logic              clk,
    input  logic              adv,
    input  gccs_pkg::box_t    box,
    output gccs_pkg::lane_in_t lane_in [DIMENSIONS]
);
    import gccs_pkg::*;

    logic [LENGTH_WIDTH-1:0] raw [MAX_DIM];
    logic  ok_next;
    base_t pr_next [DIMENSIONS];

    // stage 1
    mag_t   p1_len_reg [DIMENSIONS];
    count_t p1_cnt_reg;
    logic   p1_ok_reg;
    base_t  p1_sq_reg  [DIMENSIONS];
    cl_t    p1_cl_reg  [DIMENSIONS];
    base_t  p1_pr_reg  [DIMENSIONS];
    // stage 2
    mag_t                 p2_len_reg    [DIMENSIONS];
    logic                 p2_ok_reg;
    logic [SUM_WIDTH-1:0] p2_sum_reg;
    logic [SQK_WIDTH-1:0] p2_sqk_reg    [DIMENSIONS];
    cl_t                  p2_cl_reg     [DIMENSIONS];
    base_t                p2_pr_reg     [DIMENSIONS];
    cl_t                  p2_rhs_lo_reg [DIMENSIONS];
    cl_t                  p2_rhs_hi_reg [DIMENSIONS];
    // stage 3
    mag_t  p3_len_reg  [DIMENSIONS];
    logic  p3_ok_reg;
    logic  p3_deg_reg  [DIMENSIONS];
    cl_t   p3_cl_reg   [DIMENSIONS];
    base_t p3_pr_reg   [DIMENSIONS];
    rhs_t  p3_rhs3_reg [DIMENSIONS];
    // stage 4
    logic [GW-1:0] g_next;
    lane_in_t      lane_next [DIMENSIONS];
    lane_in_t      lane_reg  [DIMENSIONS];
    logic [SUM_WIDTH-1:0] sum_next;

    always_comb
    begin
        raw[0] = box.length_x;
        raw[1] = box.length_y;
        raw[2] = box.length_z;
        ok_next = (box.element_count != '0);
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            if (raw[d] == '0 || raw[d][LENGTH_WIDTH-1])
            begin
                ok_next = 1'b0;
            end
        end
    end

    // product of the two other sides in three dimensions, else the next side alone
    for (genvar gl = 0; gl < DIMENSIONS; gl++)
    begin : g_pair
        if (DIMENSIONS == MAX_DIM)
        begin : g_three
            assign pr_next[gl] = SQ_WIDTH'(raw[(gl + 1) % MAX_DIM][MAG_WIDTH-1:0])
                               * SQ_WIDTH'(raw[(gl + 2) % MAX_DIM][MAG_WIDTH-1:0]);
        end
        else
        begin : g_two
            assign pr_next[gl] = SQ_WIDTH'(raw[(gl + 1) % DIMENSIONS][MAG_WIDTH-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cnt_reg <= box.element_count;
            p1_ok_reg  <= ok_next;
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                p1_len_reg[d] <= raw[d][MAG_WIDTH-1:0];
                p1_sq_reg[d]  <= SQ_WIDTH'(raw[d][MAG_WIDTH-1:0])
                               * SQ_WIDTH'(raw[d][MAG_WIDTH-1:0]);
                p1_cl_reg[d]  <= CL_WIDTH'(box.element_count)
                               * CL_WIDTH'(raw[d][MAG_WIDTH-1:0]);
                p1_pr_reg[d]  <= pr_next[d];
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            sum_next = sum_next + SUM_WIDTH'(p1_sq_reg[d]);
        end
    end

    // count * side^2 as two half products, summed in the next stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_ok_reg  <= p1_ok_reg && (p1_cnt_reg != '0);
            p2_sum_reg <= sum_next;
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                p2_len_reg[d]    <= p1_len_reg[d];
                p2_sqk_reg[d]    <= SQK_WIDTH'(p1_sq_reg[d]) * SQK_WIDTH'(EPS_ROOT);
                p2_cl_reg[d]     <= p1_cl_reg[d];
                p2_pr_reg[d]     <= p1_pr_reg[d];
                p2_rhs_lo_reg[d] <= CL_WIDTH'(p1_cnt_reg)
                                  * CL_WIDTH'(p1_sq_reg[d][MAG_WIDTH-1:0]);
                p2_rhs_hi_reg[d] <= CL_WIDTH'(p1_cnt_reg)
                                  * CL_WIDTH'(p1_sq_reg[d][SQ_WIDTH-1:MAG_WIDTH]);
            end
        end
    end

    // side^2 * 1e8 < sum of squares marks a degenerate side
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_ok_reg <= p2_ok_reg;
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                p3_len_reg[d]  <= p2_len_reg[d];
                p3_deg_reg[d]  <= (SQE_WIDTH'(p2_sqk_reg[d]) * SQE_WIDTH'(EPS_ROOT))
                                < SQE_WIDTH'(p2_sum_reg);
                p3_cl_reg[d]   <= p2_cl_reg[d];
                p3_pr_reg[d]   <= p2_pr_reg[d];
                p3_rhs3_reg[d] <= RHS_WIDTH'(p2_rhs_lo_reg[d])
                                + (RHS_WIDTH'(p2_rhs_hi_reg[d]) << MAG_WIDTH);
            end
        end
    end

    always_comb
    begin
        g_next = '0;
        for (int d = 0; d < DIMENSIONS; d++)
        begin
            if (!p3_deg_reg[d])
            begin
                g_next = g_next + GW'(1);
            end
        end
        for (int i = 0; i < DIMENSIONS; i++)
        begin
            lane_next[i].tag.ok  = p3_ok_reg;
            lane_next[i].tag.deg = p3_deg_reg[i];
            lane_next[i].g       = g_next;
            lane_next[i].rhs     = RHS_WIDTH'(p3_cl_reg[i]);
            if (g_next == GW'(DIMENSIONS))
            begin
                lane_next[i].base = p3_pr_reg[i];
                if (DIMENSIONS == MAX_DIM)
                begin
                    lane_next[i].rhs = p3_rhs3_reg[i];
                end
            end
            else if (g_next == G_ONE)
            begin
                lane_next[i].base = SQ_WIDTH'(FRAC_ONE);
            end
            else
            begin
                lane_next[i].base = '0;
                for (int j = 0; j < DIMENSIONS; j++)
                begin
                    if (j != i && !p3_deg_reg[j])
                    begin
                        lane_next[i].base = SQ_WIDTH'(p3_len_reg[j]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < DIMENSIONS; d++)
            begin
                lane_reg[d] <= lane_next[d];
            end
        end
    end

    assign lane_in = lane_reg;

endmodule

FILE: rtl/gccs_root_lane.sv
// One lane: bit-per-stage search for the largest n with base * n^g <= rhs.
module gccs_root_lane (
    input  logic                clk,
    input  logic                adv,
    input  gccs_pkg::lane_in_t  lane_in,
    output gccs_pkg::cell_t     n,
    output gccs_pkg::lane_tag_t tag
);
    import gccs_pkg::*;

    localparam int STEPS = CELL_WIDTH;

    lane_in_t st_reg [STEPS];
    cell_t    n_reg  [STEPS];
    // running base*n, base*n^2, base*n^3 for the bits kept so far
    logic [PROD_WIDTH-1:0] a1_reg [STEPS-1];
    logic [PROD_WIDTH-1:0] a2_reg [STEPS-1];
    logic [PROD_WIDTH-1:0] a3_reg [STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int SH = STEPS - 1 - k;

        lane_in_t              src;
        cell_t                 n_src;
        logic [PROD_WIDTH-1:0] a1_src;
        logic [PROD_WIDTH-1:0] a2_src;
        logic [PROD_WIDTH-1:0] a3_src;
        logic [PROD_WIDTH-1:0] bw;
        logic [PROD_WIDTH-1:0] t1;
        logic [PROD_WIDTH-1:0] t2;
        logic [PROD_WIDTH-1:0] t3;
        logic [PROD_WIDTH-1:0] lhs;
        logic                  hit;

        if (k == 0)
        begin : g_first
            assign src    = lane_in;
            assign n_src  = '0;
            assign a1_src = '0;
            assign a2_src = '0;
            assign a3_src = '0;
        end
        else
        begin : g_rest
            assign src    = st_reg[k-1];
            assign n_src  = n_reg[k-1];
            assign a1_src = a1_reg[k-1];
            assign a2_src = a2_reg[k-1];
            assign a3_src = a3_reg[k-1];
        end

        // (n + b)^g expanded with b = 2^SH: shifts and adds only
        always_comb
        begin
            bw  = PROD_WIDTH'(src.base);
            t1  = a1_src + (bw << SH);
            t2  = a2_src + (a1_src << (SH + 1)) + (bw << (2 * SH));
            t3  = a3_src + (a2_src << SH) + (a2_src << (SH + 1))
                + (a1_src << (2 * SH)) + (a1_src << (2 * SH + 1)) + (bw << (3 * SH));
            case (src.g)
                G_ONE:   lhs = t1;
                G_TWO:   lhs = t2;
                default: lhs = t3;
            endcase
            hit = (lhs <= PROD_WIDTH'(src.rhs));
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= src;
                n_reg[k]  <= hit ? (n_src | (CELL_WIDTH'(1) << SH)) : n_src;
            end
        end

        if (k < STEPS - 1)
        begin : g_acc
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    a1_reg[k] <= hit ? t1 : a1_src;
                    a2_reg[k] <= hit ? t2 : a2_src;
                    a3_reg[k] <= hit ? t3 : a3_src;
                end
            end
        end
    end

    assign n   = n_reg[STEPS-1];
    assign tag = st_reg[STEPS-1].tag;

endmodule
